// ===== rtl/core/gradient_noise_2d_assert.svh =====
// Assertion macros used by the gradient noise RTL.
`ifndef GRADIENT_NOISE_2D_ASSERT_SVH
`define GRADIENT_NOISE_2D_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define GN2D_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define GN2D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gn2d_pkg.sv =====
// Constants, widths and the corner gradient function of the 2D gradient noise block.
`timescale 1ns / 1ps
`default_nettype none

package gn2d_pkg;

    // Fixed-point format of the fractional parts
    localparam int FRAC_BITS = 16;
    localparam int ONE       = 1 << FRAC_BITS;

    // Stream widths
    localparam int COORD_W   = 32;
    localparam int IN_TDW    = 2 * COORD_W;

    // Internal widths
    localparam int TW  = FRAC_BITS;          // fractional part t
    localparam int QW  = FRAC_BITS + 4;      // 15*ONE-6t, r, s
    localparam int MQW = 2 * FRAC_BITS + 4;  // t*q and t3*s products
    localparam int MTW = 2 * FRAC_BITS;      // t*t and t2*t products
    localparam int FW  = FRAC_BITS + 1;      // fade weight, 0..ONE
    localparam int DXW = FRAC_BITS + 2;      // corner offset, -ONE..ONE-1
    localparam int GW  = FRAC_BITS + 3;      // gradient and noise value
    localparam int DW  = FRAC_BITS + 4;      // lerp difference
    localparam int PW  = 2 * FRAC_BITS + 6;  // lerp product

    localparam int OUT_TDW = ((GW + 7) / 8) * 8;

    localparam int NUM_STAGES = 8;

    localparam logic signed [DXW-1:0] ONE_DX = DXW'(ONE);

    // Gradient dot product: bit 0 negates the first term; bit 1 swaps dx and dy and negates the doubled second
    function automatic logic signed [GW-1:0] corner_grad(
        input logic [1:0]            hash,
        input logic signed [DXW-1:0] dx,
        input logic signed [DXW-1:0] dy
    );
        logic signed [GW-1:0] first;
        logic signed [GW-1:0] second;
        logic signed [GW-1:0] term_a;
        logic signed [GW-1:0] term_b;
        first  = hash[1] ? GW'(dy) : GW'(dx);
        second = hash[1] ? GW'(dx) : GW'(dy);
        term_a = hash[0] ? -first : first;
        term_b = hash[1] ? -(second <<< 1) : (second <<< 1);
        return term_a + term_b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gradient_noise_2d.sv =====
// 2D gradient noise: eight-stage pipeline from a Q15.16 point to a Q2.16 noise value.
// Path: an accepted input item is registered through stages 1 to 8 in order, and the
//   result is presented from the stage 8 register.
// Throughput: one item per cycle when not stalled; each stage holds one item, moving
//   on when the stage after it is empty or moving, so bubbles fill while output waits.
// No stage chains more than one multiply (fade chain three deep, lerps two deep).
// Reset (i_rst_n low, synchronous) empties all stages; no item is in flight after.
`timescale 1ns / 1ps
`default_nettype none
`include "gradient_noise_2d_assert.svh"

module gradient_noise_2d (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input item stream
    input  wire logic                              i_s_axis_tvalid,
    output      logic                              o_s_axis_tready,
    input  wire logic [gn2d_pkg::IN_TDW-1:0]       i_s_axis_tdata,   // coord_x, coord_y
    // result item stream
    output      logic                              o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output      logic [gn2d_pkg::OUT_TDW-1:0]      o_m_axis_tdata    // noise_value, zero pad
);

    localparam int F   = gn2d_pkg::FRAC_BITS;
    localparam int NST = gn2d_pkg::NUM_STAGES;
    localparam int TW  = gn2d_pkg::TW;
    localparam int QW  = gn2d_pkg::QW;
    localparam int MQW = gn2d_pkg::MQW;
    localparam int MTW = gn2d_pkg::MTW;
    localparam int FW  = gn2d_pkg::FW;
    localparam int DXW = gn2d_pkg::DXW;
    localparam int GW  = gn2d_pkg::GW;
    localparam int DW  = gn2d_pkg::DW;
    localparam int PW  = gn2d_pkg::PW;
    localparam int CW  = gn2d_pkg::COORD_W;

    localparam logic signed [GW-1:0] NOISE_LIM = GW'(3 * gn2d_pkg::ONE);

    // Stage valid bits and per-stage advance
    logic [NST:1]   r_vld;
    logic [NST+1:1] w_adv;

    // Stage 1: fractions, q = 15*ONE - 6t, corner gradients (00, 10, 01, 11)
    logic [TW-1:0]          n1_tx, n1_ty, r1_tx, r1_ty;
    logic [QW-1:0]          n1_qx, n1_qy, r1_qx, r1_qy;
    logic signed [GW-1:0]   n1_g [4];
    logic signed [GW-1:0]   r1_g [4];
    // Stage 2: t2, r
    logic [TW-1:0]          n2_t2x, n2_t2y, r2_t2x, r2_t2y, r2_tx, r2_ty;
    logic [QW-1:0]          n2_rx, n2_ry, r2_rx, r2_ry;
    logic signed [GW-1:0]   r2_g [4];
    // Stage 3: t3, s
    logic [TW-1:0]          n3_t3x, n3_t3y, r3_t3x, r3_t3y;
    logic [QW-1:0]          n3_sx, n3_sy, r3_sx, r3_sy;
    logic signed [GW-1:0]   r3_g [4];
    // Stage 4: fade weights
    logic [FW-1:0]          n4_u, n4_v, r4_u, r4_v;
    logic signed [GW-1:0]   r4_g [4];
    // Stage 5: x lerp products
    logic signed [PW-1:0]   n5_plo, n5_phi, r5_plo, r5_phi;
    logic signed [GW-1:0]   r5_g00, r5_g01;
    logic [FW-1:0]          r5_v;
    // Stage 6: x lerp results
    logic signed [GW-1:0]   n6_lo, n6_hi, r6_lo, r6_hi;
    logic [FW-1:0]          r6_v;
    // Stage 7: y lerp product
    logic signed [PW-1:0]   n7_py, r7_py;
    logic signed [GW-1:0]   r7_lo;
    // Stage 8: output register
    logic signed [GW-1:0]   n8_res, r8_res;

    // Advance chain: a stage loads when it is empty or its item moves on
    always_comb begin
        w_adv[NST+1] = i_m_axis_tready;
        for (int k = NST; k >= 1; k--) begin
            w_adv[k] = ~r_vld[k] | w_adv[k+1];
        end
    end

    assign o_s_axis_tready = w_adv[1];
    assign o_m_axis_tvalid = r_vld[NST];
    assign o_m_axis_tdata  = gn2d_pkg::OUT_TDW'({1'b0, r8_res[GW-1:0]} & {1'b0, {GW{1'b1}}});

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[1]) begin
                r_vld[1] <= i_s_axis_tvalid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1 logic: cell hash low bits, offsets and gradients
    always_comb begin
        logic [1:0]            h;
        logic signed [DXW-1:0] dx0, dx1, dy0, dy1;
        h     = i_s_axis_tdata[F+1:F] + i_s_axis_tdata[CW+F+1:CW+F];
        n1_tx = i_s_axis_tdata[F-1:0];
        n1_ty = i_s_axis_tdata[CW+F-1:CW];
        dx0   = $signed({2'b00, n1_tx});
        dy0   = $signed({2'b00, n1_ty});
        dx1   = dx0 - gn2d_pkg::ONE_DX;
        dy1   = dy0 - gn2d_pkg::ONE_DX;
        n1_qx = QW'(15 * gn2d_pkg::ONE) - (QW'(n1_tx) << 2) - (QW'(n1_tx) << 1);
        n1_qy = QW'(15 * gn2d_pkg::ONE) - (QW'(n1_ty) << 2) - (QW'(n1_ty) << 1);
        n1_g[0] = gn2d_pkg::corner_grad(h,          dx0, dy0);
        n1_g[1] = gn2d_pkg::corner_grad(h + 2'd1,   dx1, dy0);
        n1_g[2] = gn2d_pkg::corner_grad(h + 2'd1,   dx0, dy1);
        n1_g[3] = gn2d_pkg::corner_grad(h + 2'd2,   dx1, dy1);
    end

    // Stage 2 logic: t2 = t*t >> F, r = t*q >> F
    always_comb begin
        logic [MTW-1:0] mtx, mty;
        logic [MQW-1:0] mqx, mqy;
        mtx    = MTW'(r1_tx) * MTW'(r1_tx);
        mty    = MTW'(r1_ty) * MTW'(r1_ty);
        mqx    = MQW'(r1_tx) * MQW'(r1_qx);
        mqy    = MQW'(r1_ty) * MQW'(r1_qy);
        n2_t2x = mtx[MTW-1:F];
        n2_t2y = mty[MTW-1:F];
        n2_rx  = mqx[MQW-1:F];
        n2_ry  = mqy[MQW-1:F];
    end

    // Stage 3 logic: t3 = t2*t >> F, s = 10*ONE - r
    always_comb begin
        logic [MTW-1:0] mx, my;
        mx     = MTW'(r2_t2x) * MTW'(r2_tx);
        my     = MTW'(r2_t2y) * MTW'(r2_ty);
        n3_t3x = mx[MTW-1:F];
        n3_t3y = my[MTW-1:F];
        n3_sx  = QW'(10 * gn2d_pkg::ONE) - r2_rx;
        n3_sy  = QW'(10 * gn2d_pkg::ONE) - r2_ry;
    end

    // Stage 4 logic: fade = t3*s >> F, clamped to one
    always_comb begin
        logic [MQW-1:0] mx, my;
        logic [QW-1:0]  fx, fy;
        mx   = MQW'(r3_t3x) * MQW'(r3_sx);
        my   = MQW'(r3_t3y) * MQW'(r3_sy);
        fx   = mx[MQW-1:F];
        fy   = my[MQW-1:F];
        n4_u = (fx > QW'(gn2d_pkg::ONE)) ? FW'(gn2d_pkg::ONE) : fx[FW-1:0];
        n4_v = (fy > QW'(gn2d_pkg::ONE)) ? FW'(gn2d_pkg::ONE) : fy[FW-1:0];
    end

    // Stage 5 logic: u * (g10 - g00) and u * (g11 - g01)
    always_comb begin
        logic signed [DW-1:0] dlo, dhi;
        dlo    = DW'(r4_g[1]) - DW'(r4_g[0]);
        dhi    = DW'(r4_g[3]) - DW'(r4_g[2]);
        n5_plo = PW'($signed({1'b0, r4_u})) * PW'(dlo);
        n5_phi = PW'($signed({1'b0, r4_u})) * PW'(dhi);
    end

    // Stage 6 logic: finish x lerps, arithmetic shift gives the floor
    always_comb begin
        logic signed [PW-1:0] slo, shi;
        slo   = PW'(r5_g00) + (r5_plo >>> F);
        shi   = PW'(r5_g01) + (r5_phi >>> F);
        n6_lo = slo[GW-1:0];
        n6_hi = shi[GW-1:0];
    end

    // Stage 7 logic: v * (hi - lo)
    always_comb begin
        logic signed [DW-1:0] dy;
        dy    = DW'(r6_hi) - DW'(r6_lo);
        n7_py = PW'($signed({1'b0, r6_v})) * PW'(dy);
    end

    // Stage 8 logic: finish y lerp
    always_comb begin
        logic signed [PW-1:0] sres;
        sres   = PW'(r7_lo) + (r7_py >>> F);
        n8_res = sres[GW-1:0];
    end

    // Stage payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_tx <= n1_tx;
            r1_ty <= n1_ty;
            r1_qx <= n1_qx;
            r1_qy <= n1_qy;
            r1_g  <= n1_g;
        end
        if (w_adv[2]) begin
            r2_t2x <= n2_t2x;
            r2_t2y <= n2_t2y;
            r2_rx  <= n2_rx;
            r2_ry  <= n2_ry;
            r2_tx  <= r1_tx;
            r2_ty  <= r1_ty;
            r2_g   <= r1_g;
        end
        if (w_adv[3]) begin
            r3_t3x <= n3_t3x;
            r3_t3y <= n3_t3y;
            r3_sx  <= n3_sx;
            r3_sy  <= n3_sy;
            r3_g   <= r2_g;
        end
        if (w_adv[4]) begin
            r4_u <= n4_u;
            r4_v <= n4_v;
            r4_g <= r3_g;
        end
        if (w_adv[5]) begin
            r5_plo <= n5_plo;
            r5_phi <= n5_phi;
            r5_g00 <= r4_g[0];
            r5_g01 <= r4_g[2];
            r5_v   <= r4_v;
        end
        if (w_adv[6]) begin
            r6_lo <= n6_lo;
            r6_hi <= n6_hi;
            r6_v  <= r5_v;
        end
        if (w_adv[7]) begin
            r7_py <= n7_py;
            r7_lo <= r6_lo;
        end
        if (w_adv[8]) begin
            r8_res <= n8_res;
        end
    end

    // Checks
    `GN2D_ASSERT_SAME(a_noise_range, i_clk, i_rst_n, o_m_axis_tvalid, (r8_res <= NOISE_LIM) && (r8_res >= -NOISE_LIM), "noise value out of range")
    `GN2D_ASSERT_SAME(a_fade_clamp, i_clk, i_rst_n, r_vld[4], (r4_u <= FW'(gn2d_pkg::ONE)) && (r4_v <= FW'(gn2d_pkg::ONE)), "fade weight above one")
    `GN2D_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_vld[1], "accepted item missing from first stage")
    `GN2D_ASSERT_NEXT(a_mid_hold, i_clk, i_rst_n, r_vld[5] && !w_adv[6], r_vld[5] && $stable(r5_plo), "stalled item lost in lerp stage")

endmodule

`default_nettype wire
